// ===== sv/ddo_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table for the odometry block.
// No dependencies; every other file of the block imports this package.
package ddo_pkg;

    // CORDIC iterations; the range supported is 12 to 32
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CORDIC_W     = 36;
    localparam int CORDIC_CNT_W = 5;

    // bit-serial multiplier: magnitude A times magnitude B
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 34;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // restoring divider, one quotient bit per cycle
    localparam int DIV_N_W   = 68;
    localparam int DIV_D_W   = 32;
    localparam int DIV_Q_W   = 47;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 36'sd652032874;
    localparam logic [DIV_Q_W:0] RADIUS_CAP = 48'h4000_0000_0000;

    typedef enum logic [2:0] {
        REG_LEFT_SCALE    = 3'd0,
        REG_RIGHT_SCALE   = 3'd1,
        REG_INVERSE_TRACK = 3'd2,
        REG_TURN_DEADBAND = 3'd3,
        REG_GYRO_DEADBAND = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_L, ST_MUL_R, ST_MUL_T, ST_WRAP, ST_COS0, ST_DIV_Q,
        ST_DIV_H, ST_COS1, ST_MUL_X, ST_MUL_Y, ST_DONE
    } t_state;

    // arctan(2^-i) in Q2.30, truncated
    function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [CORDIC_W-1:0] v;
        case (i)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd8;
            5'd28: v = 36'sd4;
            5'd29: v = 36'sd2;
            5'd30: v = 36'sd1;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ddo_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on ddo_pkg.
module ddo_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ddo_pkg::MUL_A_W-1:0]  i_a,
    input  logic [ddo_pkg::MUL_B_W-1:0]  i_b,
    output logic                         o_done,
    output logic [ddo_pkg::MUL_P_W-1:0]  o_prod
);
    import ddo_pkg::*;

    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_P_W-1:0]   r_acc;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[MUL_P_W-2:0], 1'b0}
                   + (r_b[MUL_B_W-1] ? MUL_P_W'(r_a) : '0);
            r_b   <= {r_b[MUL_B_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== sv/ddo_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient capped at the radius limit.
// Depends on ddo_pkg.
module ddo_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ddo_pkg::DIV_N_W-1:0]  i_num,
    input  logic [ddo_pkg::DIV_D_W-1:0]  i_den,
    output logic                         o_done,
    output logic [ddo_pkg::DIV_Q_W-1:0]  o_quot
);
    import ddo_pkg::*;

    logic [DIV_N_W-1:0]   r_num;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_Q_W:0]     r_q;
    logic                 r_ovf;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_D_W:0]     w_rem_sh;
    logic                 w_ge;

    assign w_rem_sh = {r_rem, r_num[DIV_N_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_N_W-2:0], 1'b0};
            r_rem <= DIV_D_W'(w_ge ? w_rem_sh - {1'b0, r_den} : w_rem_sh);
            r_q   <= {r_q[DIV_Q_W-1:0], w_ge};
            // a bit shifted out of the top means the quotient is far past the cap
            r_ovf <= r_ovf | r_q[DIV_Q_W];
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_ovf || (r_q > RADIUS_CAP)) ? RADIUS_CAP[DIV_Q_W-1:0]
                                                  : r_q[DIV_Q_W-1:0];

endmodule

// ===== sv/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ddo_pkg (step count, gain, arctangent table).
module ddo_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [31:0]                  i_angle,
    output logic                                o_done,
    output logic signed [ddo_pkg::CORDIC_W-1:0] o_cos,
    output logic signed [ddo_pkg::CORDIC_W-1:0] o_sin
);
    import ddo_pkg::*;

    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    logic                       r_neg;
    logic [CORDIC_CNT_W-1:0]    r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic signed [33:0]         w_ang;
    logic signed [33:0]         w_fold;
    logic                       w_neg;
    logic signed [CORDIC_W-1:0] w_tx, w_ty, w_at;

    // fold angles beyond a quarter turn by pi and negate the results
    always_comb begin
        w_ang  = 34'(i_angle);
        w_fold = w_ang;
        w_neg  = 1'b0;
        if (w_ang > HALF_PI_Q28) begin
            w_fold = w_ang - PI_Q28;
            w_neg  = 1'b1;
        end else if (w_ang < -HALF_PI_Q28) begin
            w_fold = w_ang + PI_Q28;
            w_neg  = 1'b1;
        end
    end

    assign w_tx = r_y >>> r_cnt;
    assign w_ty = r_x >>> r_cnt;
    assign w_at = atan_q30(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CORDIC_CNT_W'(CORDIC_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= CORDIC_GAIN_Q30;
            r_y   <= '0;
            r_z   <= CORDIC_W'(w_fold) <<< 2;
            r_neg <= w_neg;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_tx;
                r_y <= r_y + w_ty;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_tx;
                r_y <= r_y - w_ty;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ===== sv/diff_drive_odometry.sv =====
// Top level of the differential-drive odometry block: sequencer, state and ports.
// Depends on ddo_pkg, ddo_mul, ddo_div and ddo_cordic.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | left_count, right_count, gyro_step
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | heading, pos_x, pos_y, gyro_total
//  cfg      | in        | i_cfg_valid / o_cfg_ready     | register index, write data
//
// One item at a time. A multiply works serially through its 34 multiplier bits, a divide
// through its 68 dividend bits, a sine/cosine through its CORDIC micro-rotations. A
// straight move uses five multiplies and one CORDIC; an arc adds one more CORDIC and two
// divides, or one when the inverse track is zero. A heading wrap takes one 2*pi step at
// a time. The shared bit-serial multiplier, divider and CORDIC set the rate.
// Reset (synchronous, active low) clears position, heading and gyro sum and loads the
// register defaults. A beat waiting on m_axis does not block the next input beat; the
// sequencer holds only when its own result is ready and the output beat is still stalled.
module diff_drive_odometry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] left_count, [31:16] right_count, [63:32] gyro_step
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] heading, [63:32] pos_x, [95:64] pos_y, [127:96] gyro_total
    output logic [127:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [27:0]  i_cfg_data
);
    import ddo_pkg::*;

    // configuration registers
    logic [23:0] r_left_scale, r_right_scale, r_inv_track;
    logic [19:0] r_turn_db;
    logic [27:0] r_gyro_db;

    // architectural state
    logic signed [31:0] r_heading, r_x, r_y, r_gyro;

    // sequencer
    t_state r_state, n_state;
    logic   r_run, n_run;
    logic   r_out_valid;
    logic [127:0] r_out_data;

    // per-item working registers
    logic [15:0]        r_lc, r_rc;
    logic signed [41:0] r_wayl, r_wayr;
    logic signed [31:0] r_ddir;
    logic signed [33:0] r_nw;
    logic signed [CORDIC_W-1:0] r_c0, r_s0;
    logic signed [DIV_Q_W:0]    r_q;
    logic [39:0]        r_half;
    logic               r_turn;
    logic signed [53:0] r_dx, r_dy;

    // unit ports
    logic                 w_mul_start, w_mul_done;
    logic [MUL_A_W-1:0]   w_mul_a;
    logic [MUL_B_W-1:0]   w_mul_b;
    logic [MUL_P_W-1:0]   w_prod;
    logic                 w_div_start, w_div_done;
    logic [DIV_N_W-1:0]   w_div_num;
    logic [DIV_D_W-1:0]   w_div_den;
    logic [DIV_Q_W-1:0]   w_quot;
    logic                 w_cor_start, w_cor_done;
    logic signed [31:0]   w_cor_ang;
    logic signed [CORDIC_W-1:0] w_c1, w_s1;

    // derived values
    logic [15:0]        w_lc_mag, w_rc_mag;
    logic signed [41:0] w_pw, w_way_new;
    logic signed [42:0] w_diff;
    logic [42:0]        w_dm;
    logic [69:0]        w_t;
    logic               w_t_gt_max, w_t_gt_min;
    logic signed [31:0] w_ddir_new;
    logic [31:0]        w_ddm;
    logic               w_turn;
    logic [41:0]        w_wayl_mag, w_wayr_mag;
    logic signed [48:0] w_r;
    logic [48:0]        w_r_mag;
    logic signed [36:0] w_cd, w_sd;
    logic [36:0]        w_cd_mag, w_sd_mag;
    logic [CORDIC_W-1:0] w_s0_mag, w_c0_mag;
    logic               w_mul_neg;
    logic signed [53:0] w_dp, w_dv;
    logic [31:0]        w_g_mag;
    logic signed [32:0] w_g_sum;
    logic signed [54:0] w_x_sum, w_y_sum;
    logic               w_in_beat, w_out_load;

    function automatic logic signed [31:0] sat32(input logic signed [54:0] v);
        if ((&v[54:31]) || !(|v[54:31])) return v[31:0];
        return v[54] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---- arithmetic around the shared units ----
    assign w_lc_mag = r_lc[15] ? 16'd0 - r_lc : r_lc;
    assign w_rc_mag = r_rc[15] ? 16'd0 - r_rc : r_rc;
    assign w_pw     = $signed({1'b0, w_prod[40:0]});
    // the sign of the count being scaled decides the sign of the travel
    assign w_way_new = ((r_state == ST_MUL_L) ? r_lc[15] : r_rc[15]) ? -w_pw : w_pw;

    assign w_diff = 43'(r_wayr) - 43'(r_wayl);
    assign w_dm   = w_diff[42] ? 43'd0 - w_diff : w_diff;
    assign w_t    = w_prod[81:12];
    assign w_t_gt_max = |w_t[69:31];
    assign w_t_gt_min = (|w_t[69:32]) || (w_t[31] && (|w_t[30:0]));

    // heading change, truncated toward zero and saturated
    always_comb begin
        if (!w_diff[42]) w_ddir_new = w_t_gt_max ? 32'sh7FFF_FFFF : w_t[31:0];
        else             w_ddir_new = w_t_gt_min ? 32'sh8000_0000 : 32'd0 - w_t[31:0];
    end

    assign w_ddm  = r_ddir[31] ? 32'd0 - r_ddir : r_ddir;
    assign w_turn = (r_ddir != 32'sd0) && (w_ddm >= 32'(r_turn_db));

    assign w_wayl_mag = r_wayl[41] ? 42'd0 - r_wayl : r_wayl;
    assign w_wayr_mag = r_wayr[41] ? 42'd0 - r_wayr : r_wayr;
    assign w_r        = 49'(r_q) + $signed({9'd0, r_half});
    assign w_r_mag    = w_r[48] ? 49'd0 - w_r : w_r;
    assign w_cd       = 37'(r_c0) - 37'(w_c1);
    assign w_sd       = 37'(w_s1) - 37'(r_s0);
    assign w_cd_mag   = w_cd[36] ? 37'd0 - w_cd : w_cd;
    assign w_sd_mag   = w_sd[36] ? 37'd0 - w_sd : w_sd;
    assign w_s0_mag   = r_s0[CORDIC_W-1] ? CORDIC_W'(0) - r_s0 : r_s0;
    assign w_c0_mag   = r_c0[CORDIC_W-1] ? CORDIC_W'(0) - r_c0 : r_c0;

    // operand select and result sign for the multiplier
    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_mul_neg = 1'b0;
        case (r_state)
            ST_MUL_L: begin
                w_mul_a = MUL_A_W'(w_lc_mag);
                w_mul_b = MUL_B_W'(r_left_scale);
            end
            ST_MUL_R: begin
                w_mul_a = MUL_A_W'(w_rc_mag);
                w_mul_b = MUL_B_W'(r_right_scale);
            end
            ST_MUL_T: begin
                w_mul_a = MUL_A_W'(w_dm);
                w_mul_b = MUL_B_W'(r_inv_track);
            end
            ST_MUL_X: begin
                if (r_turn) begin
                    w_mul_a   = MUL_A_W'(w_r_mag);
                    w_mul_b   = MUL_B_W'(w_cd_mag);
                    w_mul_neg = w_r[48] ^ w_cd[36];
                end else begin
                    w_mul_a   = MUL_A_W'(w_wayr_mag);
                    w_mul_b   = MUL_B_W'(w_s0_mag);
                    w_mul_neg = r_wayr[41] ^ r_s0[CORDIC_W-1];
                end
            end
            ST_MUL_Y: begin
                if (r_turn) begin
                    w_mul_a   = MUL_A_W'(w_r_mag);
                    w_mul_b   = MUL_B_W'(w_sd_mag);
                    w_mul_neg = w_r[48] ^ w_sd[36];
                end else begin
                    w_mul_a   = MUL_A_W'(w_wayr_mag);
                    w_mul_b   = MUL_B_W'(w_c0_mag);
                    w_mul_neg = r_wayr[41] ^ r_c0[CORDIC_W-1];
                end
            end
            default: ;
        endcase
    end

    // product scaled back by 2^30, magnitude truncated
    assign w_dp = $signed({2'b0, w_prod[81:30]});
    assign w_dv = w_mul_neg ? -w_dp : w_dp;

    // arc radius quotient first, then the half track
    assign w_div_num = (r_state == ST_DIV_H) ? DIV_N_W'(1) << 39
                                             : {w_wayl_mag[39:0], 28'd0};
    assign w_div_den = (r_state == ST_DIV_H) ? DIV_D_W'(r_inv_track) : w_ddm;
    assign w_cor_ang = (r_state == ST_COS0) ? r_heading : r_nw[31:0];

    assign w_g_mag = s_axis_tdata[63] ? 32'd0 - s_axis_tdata[63:32] : s_axis_tdata[63:32];
    assign w_g_sum = 33'(r_gyro) + 33'($signed(s_axis_tdata[63:32]));
    assign w_x_sum = 55'(r_x) + 55'(r_dx);
    assign w_y_sum = 55'(r_y) + 55'(r_dy);
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_cor_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_MUL_L;
            end
            ST_MUL_L, ST_MUL_R, ST_MUL_T, ST_MUL_X, ST_MUL_Y: begin
                w_mul_start = !r_run;
                n_run       = 1'b1;
                if (w_mul_done) begin
                    n_run = 1'b0;
                    unique case (r_state)
                        ST_MUL_L: n_state = ST_MUL_R;
                        ST_MUL_R: n_state = ST_MUL_T;
                        ST_MUL_T: n_state = ST_WRAP;
                        ST_MUL_X: n_state = ST_MUL_Y;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_WRAP: begin
                if (!(r_nw >= PI_Q28) && !(r_nw < -PI_Q28)) n_state = ST_COS0;
            end
            ST_COS0, ST_COS1: begin
                w_cor_start = !r_run;
                n_run       = 1'b1;
                if (w_cor_done) begin
                    n_run = 1'b0;
                    if (r_state == ST_COS1) n_state = ST_MUL_X;
                    else                    n_state = w_turn ? ST_DIV_Q : ST_MUL_X;
                end
            end
            ST_DIV_Q, ST_DIV_H: begin
                w_div_start = !r_run;
                n_run       = 1'b1;
                if (w_div_done) begin
                    n_run = 1'b0;
                    if (r_state == ST_DIV_Q && r_inv_track != 24'd0) n_state = ST_DIV_H;
                    else                                             n_state = ST_COS1;
                end
            end
            ST_DONE: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control, configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_run         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_left_scale  <= 24'd65536;
            r_right_scale <= 24'd65536;
            r_inv_track   <= 24'd209715;
            r_turn_db     <= 20'd26844;
            r_gyro_db     <= 28'd5368709;
            r_heading     <= '0;
            r_x           <= '0;
            r_y           <= '0;
            r_gyro        <= '0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_LEFT_SCALE:    r_left_scale  <= i_cfg_data[23:0];
                    REG_RIGHT_SCALE:   r_right_scale <= i_cfg_data[23:0];
                    REG_INVERSE_TRACK: r_inv_track   <= i_cfg_data[23:0];
                    REG_TURN_DEADBAND: r_turn_db     <= i_cfg_data[19:0];
                    REG_GYRO_DEADBAND: r_gyro_db     <= i_cfg_data;
                    default: ;
                endcase
            end

            // gyro sum: drop increments at or inside the deadband, saturate the rest
            if (w_in_beat && (w_g_mag > 32'(r_gyro_db))) begin
                if (w_g_sum[32] != w_g_sum[31])
                    r_gyro <= w_g_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    r_gyro <= w_g_sum[31:0];
            end

            if (w_out_load) begin
                r_heading   <= r_nw[31:0];
                r_x         <= sat32(w_x_sum);
                r_y         <= sat32(w_y_sum);
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_lc <= s_axis_tdata[15:0];
            r_rc <= s_axis_tdata[31:16];
        end
        if (w_mul_done) begin
            case (r_state)
                ST_MUL_L: r_wayl <= w_way_new;
                ST_MUL_R: r_wayr <= w_way_new;
                ST_MUL_T: begin
                    r_ddir <= w_ddir_new;
                    r_nw   <= 34'(r_heading) + 34'(w_ddir_new);
                end
                ST_MUL_X: r_dx <= w_dv;
                ST_MUL_Y: r_dy <= w_dv;
                default: ;
            endcase
        end
        // bring the new heading into [-pi, pi)
        if (r_state == ST_WRAP) begin
            if (r_nw >= PI_Q28)       r_nw <= r_nw - TWO_PI_Q28;
            else if (r_nw < -PI_Q28)  r_nw <= r_nw + TWO_PI_Q28;
        end
        if (w_cor_done && r_state == ST_COS0) begin
            r_c0   <= w_c1;
            r_s0   <= w_s1;
            r_turn <= w_turn;
        end
        if (w_div_done) begin
            if (r_state == ST_DIV_Q) begin
                r_q    <= (r_wayl[41] ^ r_ddir[31]) ? -$signed({1'b0, w_quot})
                                                    : $signed({1'b0, w_quot});
                r_half <= '0;
            end else begin
                r_half <= w_quot[39:0];
            end
        end
        if (w_out_load)
            r_out_data <= {r_gyro, sat32(w_y_sum), sat32(w_x_sum), r_nw[31:0]};
    end

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_angle (w_cor_ang),
        .o_done  (w_cor_done),
        .o_cos   (w_c1),
        .o_sin   (w_s1)
    );

endmodule

// ===== sv/ddo_checker.sv =====
// Port-level checks for the odometry block, bound to the top level.
// Depends on ddo_pkg and diff_drive_odometry.
module ddo_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    import ddo_pkg::*;

    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");

    // one item at a time: an accepted input beat closes the input side
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // reported heading stays wrapped to [-pi, pi)
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) >= -PI_Q28
                        && $signed(m_axis_tdata[31:0]) < PI_Q28))
        else $error("heading out of range");

    // no result comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a new result only appears after the sequencer was busy with an item
    a_out_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without input");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

// ===== dv/diff_drive_odometry_tb.sv =====
// Self-checking testbench for diff_drive_odometry: directed table, then random phases.
// Depends on ddo_pkg (register index names) and the diff_drive_odometry RTL.
`timescale 1ns / 100ps

module diff_drive_odometry_tb;
    import ddo_pkg::*;

    localparam longint PI_ANG      = 843314857;
    localparam longint TWO_PI_ANG  = 1686629713;
    localparam longint HALF_PI_ANG = 421657428;
    localparam longint ROT_GAIN    = 652032874;
    localparam int     ROT_STEPS   = 24;
    localparam bit [63:0] QUOT_CAP = 64'd1 << 46;
    localparam int     SETTLE_CYC  = 500;

    // arctan(2^-i), Q2.30, truncated
    localparam longint ARCTAN [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 8, 4, 2, 1, 0};

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [27:0]  i_cfg_data = '0;

    diff_drive_odometry DUT (.*);

    always #10 i_clk = ~i_clk;

    // shadow registers and pose, as the block should hold them
    longint sh_lscale, sh_rscale, sh_itrack, sh_turn_db, sh_gyro_db;
    int     pose_heading, pose_x, pose_y, gyro_sum;

    bit [127:0] pending_pose[$];
    int         n_mismatch = 0;
    int         burst_left = 0;

    typedef struct {
        shortint    lcnt;
        shortint    rcnt;
        int         gstep;
        bit         fixed;
        bit [127:0] fixed_pose;
    } t_row;

    function automatic bit [63:0] mag(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic int sat32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic void sincos(input longint ang, output longint c, output longint s);
        longint x, y, z, tx;
        bit     flip;
        x = ROT_GAIN;
        y = 0;
        flip = 0;
        if (ang > HALF_PI_ANG) begin
            ang -= PI_ANG;
            flip = 1;
        end else if (ang < -HALF_PI_ANG) begin
            ang += PI_ANG;
            flip = 1;
        end
        z = ang * 4;
        for (int i = 0; i < ROT_STEPS; i++) begin
            tx = y >>> i;
            if (z >= 0) begin
                y += x >>> i;
                x -= tx;
                z -= ARCTAN[i];
            end else begin
                y -= x >>> i;
                x += tx;
                z += ARCTAN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // (a * b) >> 30, magnitude truncated
    function automatic longint mul_frac(input longint a, input longint b);
        bit [63:0] m, n, r;
        m = mag(a);
        n = mag(b);
        r = (m >> 30) * n + (((m & 64'h3FFF_FFFF) * n) >> 30);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // (num << 28) / d, truncated, capped
    function automatic bit [63:0] radius_quot(input bit [63:0] num, input bit [63:0] d);
        bit [63:0] q, rem, nb;
        q = 0;
        rem = 0;
        for (int k = 67; k >= 0; k--) begin
            nb = (k >= 28) ? ((num >> (k - 28)) & 64'd1) : 64'd0;
            rem = (rem << 1) | nb;
            q <<= 1;
            if (rem >= d) begin
                rem -= d;
                q |= 64'd1;
            end
            if (q > QUOT_CAP) return QUOT_CAP;
        end
        return q;
    endfunction

    // advance the pose by one encoder/gyro sample, return the packed result beat
    function automatic bit [127:0] advance_pose(input shortint lc, input shortint rc,
                                                input int g);
        longint wl, wr, diff, dth, nh, c0, s0, c1, s1, q, rad, dx, dy;
        bit [63:0] dm, t, qm;
        wl = longint'(lc) * sh_lscale;
        wr = longint'(rc) * sh_rscale;
        diff = wr - wl;
        dm = mag(diff);
        t = (((dm >> 20) * 64'(sh_itrack)) << 8) + (((dm & 64'hF_FFFF) * 64'(sh_itrack)) >> 12);
        if (diff >= 0) dth = (t > 64'd2147483647) ? 64'sd2147483647 : longint'(t);
        else dth = (t > 64'd2147483648) ? -64'sd2147483648 : -longint'(t);
        nh = longint'(pose_heading) + dth;
        while (nh >= PI_ANG) nh -= TWO_PI_ANG;
        while (nh < -PI_ANG) nh += TWO_PI_ANG;
        sincos(longint'(pose_heading), c0, s0);
        if (dth != 0 && mag(dth) >= 64'(sh_turn_db)) begin
            // arc about the turn center
            qm = radius_quot(mag(wl), mag(dth));
            q = ((wl < 0) != (dth < 0)) ? -longint'(qm) : longint'(qm);
            rad = q + ((sh_itrack != 0) ? longint'((64'd1 << 39) / 64'(sh_itrack)) : 0);
            sincos(nh, c1, s1);
            dx = mul_frac(rad, c0 - c1);
            dy = mul_frac(rad, s1 - s0);
        end else begin
            dx = mul_frac(wr, s0);
            dy = mul_frac(wr, c0);
        end
        pose_heading = int'(nh);
        pose_x = sat32(longint'(pose_x) + dx);
        pose_y = sat32(longint'(pose_y) + dy);
        if (mag(longint'(g)) > 64'(sh_gyro_db)) gyro_sum = sat32(longint'(gyro_sum) + g);
        return {gyro_sum, pose_y, pose_x, pose_heading};
    endfunction

    // present one register write and hold it until taken; the caller drops valid
    task automatic write_reg(input t_reg_idx idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[27:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_LEFT_SCALE:    sh_lscale = val & 32'hFF_FFFF;
            REG_RIGHT_SCALE:   sh_rscale = val & 32'hFF_FFFF;
            REG_INVERSE_TRACK: sh_itrack = val & 32'hFF_FFFF;
            REG_TURN_DEADBAND: sh_turn_db = val & 32'hF_FFFF;
            REG_GYRO_DEADBAND: sh_gyro_db = val & 32'hFFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic write_all(input int unsigned ls, rs, it, tdb, gdb);
        write_reg(REG_LEFT_SCALE, ls);
        write_reg(REG_RIGHT_SCALE, rs);
        write_reg(REG_INVERSE_TRACK, it);
        write_reg(REG_TURN_DEADBAND, tdb);
        write_reg(REG_GYRO_DEADBAND, gdb);
        i_cfg_valid <= 1'b0;
    endtask

    // present one input beat; hold until taken, then maybe open a gap
    task automatic send_sample(input t_row r);
        bit [127:0] pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r.gstep, r.rcnt, r.lcnt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = advance_pose(r.lcnt, r.rcnt, r.gstep);
        pending_pose.push_back(r.fixed ? r.fixed_pose : pred);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 6);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // wait for every result, then let the sequencer settle before a register write
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pose.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic t_row rand_row();
        t_row r;
        r.fixed = 0;
        r.fixed_pose = '0;
        case ($urandom_range(0, 9))
            0, 1: begin
                r.lcnt = shortint'($urandom);
                r.rcnt = shortint'($urandom);
            end
            2: begin
                // near-straight: left and right counts differ by at most one
                r.lcnt = shortint'($urandom_range(0, 400)) - 16'sd200;
                r.rcnt = r.lcnt + shortint'($urandom_range(0, 2)) - 16'sd1;
            end
            default: begin
                r.lcnt = shortint'($urandom_range(0, 600)) - 16'sd300;
                r.rcnt = shortint'($urandom_range(0, 600)) - 16'sd300;
            end
        endcase
        case ($urandom_range(0, 3))
            0: r.gstep = int'($urandom);
            1: r.gstep = int'(sh_gyro_db) + $urandom_range(0, 2) - 1;
            2: r.gstep = -int'(sh_gyro_db) + $urandom_range(0, 2) - 1;
            default: r.gstep = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
        return r;
    endfunction

    // receiver: ready held high or toggled in runs, length set by a mode that changes now and then
    int rx_run = 0;
    int rx_mode = 0;
    always @(posedge i_clk) begin
        if (rx_run == 0) begin
            if ($urandom_range(0, 15) == 0) rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                    rx_run <= 40;
                end
                1: begin
                    m_axis_tready <= ~m_axis_tready;
                    rx_run <= $urandom_range(0, 3);
                end
                default: begin
                    m_axis_tready <= ~m_axis_tready;
                    rx_run <= $urandom_range(0, 60);
                end
            endcase
        end else begin
            rx_run <= rx_run - 1;
        end
    end

    // scoreboard: compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        bit [127:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pose.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                want = pending_pose.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (m_axis_tdata[f*32 +: 32] !== want[f*32 +: 32]) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("field %0d: expected %h, got %h (%0t)",
                                     f, want[f*32 +: 32], m_axis_tdata[f*32 +: 32], $realtime);
                    end
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("** diff_drive_odometry: FAILED **");
        $finish;
    end

    initial begin
        t_row dir[$];
        t_row r;
        sh_lscale = 65536;
        sh_rscale = 65536;
        sh_itrack = 209715;
        sh_turn_db = 26844;
        sh_gyro_db = 5368709;
        pose_heading = 0;
        pose_x = 0;
        pose_y = 0;
        gyro_sum = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset values, gyro deadband edge, extremes, straight and arc moves
        dir.push_back('{0, 0, 0, 1, 128'd0});
        dir.push_back('{0, 0, 5368709, 1, 128'd0});
        dir.push_back('{0, 0, -5368709, 1, 128'd0});
        dir.push_back('{0, 0, 5368710, 1, {32'd5368710, 96'd0}});
        dir.push_back('{100, 100, 0, 0, '0});
        dir.push_back('{1, 2, 0, 0, '0});
        dir.push_back('{0, 50, 0, 0, '0});
        dir.push_back('{50, 0, 0, 0, '0});
        dir.push_back('{-1, -1, 0, 0, '0});
        dir.push_back('{-32768, 32767, 32'sh7FFF_FFFF, 0, '0});
        dir.push_back('{32767, -32768, 32'sh8000_0000, 0, '0});
        dir.push_back('{32767, 32767, 32'sh7FFF_FFFF, 0, '0});
        dir.push_back('{-32768, -32768, 32'sh8000_0000, 0, '0});
        for (int i = 0; i < 6; i++) dir.push_back('{1000, -1000, 0, 0, '0});
        dir.push_back('{-5, 5, -32'sd5368710, 0, '0});
        foreach (dir[i]) send_sample(dir[i]);
        drain();

        // random phases, each under its own register setting
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: write_all(65536, 65536, 209715, 26844, 5368709);
                1: write_all(24'hFF_FFFF, 24'hFF_FFFF, 0, 0, 0);
                2: write_all(0, 0, 24'hFF_FFFF, 20'hF_FFFF, 28'hFFF_FFFF);
                3: write_all(24'hFF_FFFF, 1, 24'hFF_FFFF, 0, 1);
                4: write_all(1, 24'hFF_FFFF, 1, 1, 28'hFFF_FFFF);
                default: write_all($urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF),
                                   $urandom_range(1, 24'hFF_FFFF), $urandom_range(0, 20'hF_FFFF),
                                   $urandom_range(0, 28'hFFF_FFFF));
            endcase
            repeat ($urandom_range(0, 5)) @(posedge i_clk);
            for (int k = 0; k < 86; k++) begin
                r = rand_row();
                send_sample(r);
            end
            drain();
        end

        if (n_mismatch == 0) begin
            $display("** diff_drive_odometry: PASSED **");
        end else begin
            $display("** diff_drive_odometry: FAILED **");
        end
        $finish;
    end

endmodule
